>>> design/priority_flow_control_manager_macros.svh
// Assertion helpers for the PFC manager.
`ifndef PRIORITY_FLOW_CONTROL_MANAGER_MACROS_SVH
`define PRIORITY_FLOW_CONTROL_MANAGER_MACROS_SVH

// Same-cycle implication, held off during reset.
`define PFCM_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pfcm assertion failed");

// Next-cycle implication, held off during reset.
`define PFCM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pfcm assertion failed");

`endif

>>> design/pfcm_pkg.sv
package pfcm_pkg;

    localparam int MAX_PRIO           = 8;
    localparam int DEF_NUM_PRIORITIES = 8;
    localparam int VALUE_W            = 16;
    localparam int CNT_W              = 32;
    localparam int PRIO_W             = 8;
    localparam int CFG_IDX_W          = 3;
    localparam int CFG_DATA_W         = 64;
    localparam int LANES_PER_WORD     = CFG_DATA_W / VALUE_W;

    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_RX   = 2'd0;
    localparam cmd_t CMD_TICK = 2'd1;
    localparam cmd_t CMD_GEN  = 2'd2;
    localparam cmd_t CMD_READ = 2'd3;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_PFC_ENABLE      = 3'd0;
    localparam cfg_idx_t REG_PRIO_MASK       = 3'd1;
    localparam cfg_idx_t REG_THRESHOLD_LOW   = 3'd2;
    localparam cfg_idx_t REG_THRESHOLD_HIGH  = 3'd3;
    localparam cfg_idx_t REG_PAUSE_TIME_LOW  = 3'd4;
    localparam cfg_idx_t REG_PAUSE_TIME_HIGH = 3'd5;

    localparam logic [VALUE_W-1:0] CNT_IDX_RX         = 16'd0;
    localparam logic [VALUE_W-1:0] CNT_IDX_TX         = 16'd1;
    localparam logic [VALUE_W-1:0] CNT_IDX_PAUSE_BASE = 16'd2;

    typedef struct packed {
        logic               go;
        cmd_t               cmd;
        logic               pfc_en;
        logic [VALUE_W-1:0] quanta;
    } lane_ctrl_t;

    typedef struct packed {
        logic               send;
        logic [VALUE_W-1:0] send_time;
        logic               paused;
    } lane_stat_t;

endpackage

>>> design/pfcm_lane.sv
module pfcm_lane
    import pfcm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  lane_ctrl_t         ctrl,
    input  logic               frame_bit,
    input  logic               prio_on,
    input  logic [VALUE_W-1:0] value,
    input  logic [VALUE_W-1:0] threshold,
    input  logic [VALUE_W-1:0] pause_quanta,
    output lane_stat_t         stat,
    output logic [CNT_W-1:0]   total
);

    logic [VALUE_W-1:0] timer_reg, timer_next;
    logic [CNT_W-1:0]   total_reg, total_next;
    logic               signalled_reg, signalled_next;
    logic [VALUE_W-1:0] elapsed;
    logic               send;
    logic [VALUE_W-1:0] send_time;

    always_comb begin
        timer_next     = timer_reg;
        total_next     = total_reg;
        signalled_next = signalled_reg;
        send           = 1'b0;
        send_time      = '0;
        elapsed        = (ctrl.quanta >= timer_reg) ? timer_reg : ctrl.quanta;
        if (ctrl.go) begin
            if (ctrl.cmd == CMD_RX) begin
                if (ctrl.pfc_en && prio_on && frame_bit) begin
                    timer_next = value;
                end
            end else if (ctrl.cmd == CMD_TICK) begin
                timer_next = timer_reg - elapsed;
                total_next = total_reg + CNT_W'(elapsed);
            end else if (ctrl.cmd == CMD_GEN && ctrl.pfc_en && prio_on) begin
                if (value >= threshold && !signalled_reg) begin
                    send           = 1'b1;
                    send_time      = pause_quanta;
                    signalled_next = 1'b1;
                end else if (value < (threshold >> 1) && signalled_reg) begin
                    send           = 1'b1;
                    signalled_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_reg     <= '0;
            total_reg     <= '0;
            signalled_reg <= 1'b0;
        end else begin
            timer_reg     <= timer_next;
            total_reg     <= total_next;
            signalled_reg <= signalled_next;
        end
    end

    assign stat.send      = send;
    assign stat.send_time = send_time;
    assign stat.paused    = prio_on && (timer_next != '0);
    assign total          = total_reg;

endmodule

>>> design/priority_flow_control_manager.sv
// Priority flow control manager.
// Input channel (s_valid/s_ready) carries one command per transaction: receive
// a PFC frame, tick the pause timers, sample queue depths and build a frame,
// or read a counter. Result channel (m_valid/m_ready) returns exactly one
// result per command with the paused mask, the generated frame fields and the
// counter read.
// Configuration port (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; write it only while no command is in flight.
// A command accepted into the input register moves on to the result register,
// which raises m_valid, once the result register is free or being read.
// Throughput is one command per cycle while the result channel is not stalled.
// A stalled result holds in the result register while one more command waits
// in the input register; s_ready drops only when both are full.
// Reset clears all timers, sent flags, counters and configuration registers.
module priority_flow_control_manager
    import pfcm_pkg::*;
#(
    parameter int NUM_PRIORITIES = DEF_NUM_PRIORITIES
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_command,
    input  logic [PRIO_W-1:0]     s_frame_priorities,
    input  logic [VALUE_W-1:0]    s_quanta,
    input  logic [VALUE_W-1:0]    s_value_0,
    input  logic [VALUE_W-1:0]    s_value_1,
    input  logic [VALUE_W-1:0]    s_value_2,
    input  logic [VALUE_W-1:0]    s_value_3,
    input  logic [VALUE_W-1:0]    s_value_4,
    input  logic [VALUE_W-1:0]    s_value_5,
    input  logic [VALUE_W-1:0]    s_value_6,
    input  logic [VALUE_W-1:0]    s_value_7,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_send_valid,
    output logic [PRIO_W-1:0]     m_send_priorities,
    output logic [VALUE_W-1:0]    m_send_time_0,
    output logic [VALUE_W-1:0]    m_send_time_1,
    output logic [VALUE_W-1:0]    m_send_time_2,
    output logic [VALUE_W-1:0]    m_send_time_3,
    output logic [VALUE_W-1:0]    m_send_time_4,
    output logic [VALUE_W-1:0]    m_send_time_5,
    output logic [VALUE_W-1:0]    m_send_time_6,
    output logic [VALUE_W-1:0]    m_send_time_7,
    output logic [PRIO_W-1:0]     m_paused_mask,
    output logic [CNT_W-1:0]      m_counter_value,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "priority_flow_control_manager_macros.svh"

    // configuration
    logic                  pfc_en_reg;
    logic [PRIO_W-1:0]     prio_mask_reg;
    logic [CFG_DATA_W-1:0] thr_lo_reg, thr_hi_reg;
    logic [CFG_DATA_W-1:0] ptime_lo_reg, ptime_hi_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pfc_en_reg    <= 1'b0;
            prio_mask_reg <= '0;
            thr_lo_reg    <= '0;
            thr_hi_reg    <= '0;
            ptime_lo_reg  <= '0;
            ptime_hi_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_PFC_ENABLE:      pfc_en_reg    <= cfg_data[0];
                REG_PRIO_MASK:       prio_mask_reg <= cfg_data[PRIO_W-1:0];
                REG_THRESHOLD_LOW:   thr_lo_reg    <= cfg_data;
                REG_THRESHOLD_HIGH:  thr_hi_reg    <= cfg_data;
                REG_PAUSE_TIME_LOW:  ptime_lo_reg  <= cfg_data;
                REG_PAUSE_TIME_HIGH: ptime_hi_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    logic               in_valid_reg, in_valid_next;
    cmd_t               in_cmd_reg;
    logic [PRIO_W-1:0]  in_fbits_reg;
    logic [VALUE_W-1:0] in_quanta_reg;
    logic [VALUE_W-1:0] in_val_reg [MAX_PRIO];
    logic [VALUE_W-1:0] s_val [MAX_PRIO];
    logic               advance, go, s_fire;

    assign s_val[0] = s_value_0;
    assign s_val[1] = s_value_1;
    assign s_val[2] = s_value_2;
    assign s_val[3] = s_value_3;
    assign s_val[4] = s_value_4;
    assign s_val[5] = s_value_5;
    assign s_val[6] = s_value_6;
    assign s_val[7] = s_value_7;

    logic m_valid_reg, m_valid_next;

    assign advance = !m_valid_reg || m_ready;
    assign go      = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_cmd_reg    <= s_command;
            in_fbits_reg  <= s_frame_priorities;
            in_quanta_reg <= s_quanta;
            in_val_reg    <= s_val;
        end
    end

    // per-priority lanes
    lane_ctrl_t         ctrl;
    lane_stat_t         lane_stat  [MAX_PRIO];
    logic [CNT_W-1:0]   lane_total [NUM_PRIORITIES];
    logic [PRIO_W-1:0]  send_bits;
    logic [PRIO_W-1:0]  paused_bits;

    assign ctrl.go     = go;
    assign ctrl.cmd    = in_cmd_reg;
    assign ctrl.pfc_en = pfc_en_reg;
    assign ctrl.quanta = in_quanta_reg;

    for (genvar p = 0; p < MAX_PRIO; p++) begin : g_lane
        localparam int SLOT = p % LANES_PER_WORD;
        if (p < NUM_PRIORITIES) begin : g_on
            logic [VALUE_W-1:0] thr, ptime;
            assign thr   = (p < LANES_PER_WORD) ? thr_lo_reg[VALUE_W*SLOT +: VALUE_W]
                                                : thr_hi_reg[VALUE_W*SLOT +: VALUE_W];
            assign ptime = (p < LANES_PER_WORD) ? ptime_lo_reg[VALUE_W*SLOT +: VALUE_W]
                                                : ptime_hi_reg[VALUE_W*SLOT +: VALUE_W];
            pfcm_lane u_lane (
                .aclk         (aclk),
                .aresetn      (aresetn),
                .ctrl         (ctrl),
                .frame_bit    (in_fbits_reg[p]),
                .prio_on      (prio_mask_reg[p]),
                .value        (in_val_reg[p]),
                .threshold    (thr),
                .pause_quanta (ptime),
                .stat         (lane_stat[p]),
                .total        (lane_total[p])
            );
        end else begin : g_off
            assign lane_stat[p] = '0;
        end
        assign send_bits[p]   = lane_stat[p].send;
        assign paused_bits[p] = lane_stat[p].paused;
    end

    // global counters
    logic [CNT_W-1:0] rx_cnt_reg, rx_cnt_next;
    logic [CNT_W-1:0] tx_cnt_reg, tx_cnt_next;
    logic             send_any;
    logic             rx_hit;

    assign send_any = |send_bits;
    assign rx_hit   = go && pfc_en_reg && in_cmd_reg == CMD_RX;

    always_comb begin
        rx_cnt_next = rx_cnt_reg;
        tx_cnt_next = tx_cnt_reg;
        if (rx_hit) begin
            rx_cnt_next = rx_cnt_reg + CNT_W'(1);
        end
        if (go && send_any) begin
            tx_cnt_next = tx_cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_cnt_reg <= '0;
            tx_cnt_reg <= '0;
        end else begin
            rx_cnt_reg <= rx_cnt_next;
            tx_cnt_reg <= tx_cnt_next;
        end
    end

    // counter read
    logic [CNT_W-1:0] cval;

    always_comb begin
        cval = '0;
        if (in_cmd_reg == CMD_READ) begin
            if (in_val_reg[0] == CNT_IDX_RX) begin
                cval = rx_cnt_reg;
            end else if (in_val_reg[0] == CNT_IDX_TX) begin
                cval = tx_cnt_reg;
            end
            for (int p = 0; p < NUM_PRIORITIES; p++) begin
                if (in_val_reg[0] == CNT_IDX_PAUSE_BASE + VALUE_W'(p)) begin
                    cval = lane_total[p];
                end
            end
        end
    end

    // result register
    logic               res_send_reg;
    logic [PRIO_W-1:0]  res_prio_reg;
    logic [VALUE_W-1:0] res_time_reg [MAX_PRIO];
    logic [PRIO_W-1:0]  res_paused_reg;
    logic [CNT_W-1:0]   res_cval_reg;

    always_comb begin
        if (go) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            res_send_reg   <= send_any;
            res_prio_reg   <= send_bits;
            res_paused_reg <= paused_bits;
            res_cval_reg   <= cval;
            for (int p = 0; p < MAX_PRIO; p++) begin
                res_time_reg[p] <= lane_stat[p].send_time;
            end
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_send_valid      = res_send_reg;
    assign m_send_priorities = res_prio_reg;
    assign m_send_time_0     = res_time_reg[0];
    assign m_send_time_1     = res_time_reg[1];
    assign m_send_time_2     = res_time_reg[2];
    assign m_send_time_3     = res_time_reg[3];
    assign m_send_time_4     = res_time_reg[4];
    assign m_send_time_5     = res_time_reg[5];
    assign m_send_time_6     = res_time_reg[6];
    assign m_send_time_7     = res_time_reg[7];
    assign m_paused_mask     = res_paused_reg;
    assign m_counter_value   = res_cval_reg;

    `PFCM_ASSERT_NOW(a_send_has_bits, aclk, aresetn, m_valid && m_send_valid, m_send_priorities != '0)
    `PFCM_ASSERT_NOW(a_no_send_no_bits, aclk, aresetn, m_valid && !m_send_valid, m_send_priorities == '0)
    `PFCM_ASSERT_NOW(a_paused_enabled, aclk, aresetn, m_valid, (m_paused_mask & ~prio_mask_reg) == '0)
    `PFCM_ASSERT_NEXT(a_rx_count, aclk, aresetn, rx_hit, rx_cnt_reg == $past(rx_cnt_reg) + CNT_W'(1))
    `PFCM_ASSERT_NEXT(a_result_follows, aclk, aresetn, go, m_valid)

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import pfcm_pkg::*;

    typedef struct packed {
        cmd_t                              cmd;
        logic [PRIO_W-1:0]                 prios;
        logic [VALUE_W-1:0]                quanta;
        logic [MAX_PRIO-1:0][VALUE_W-1:0]  value;
    } pfc_item_t;

    typedef struct packed {
        logic                              send;
        logic [PRIO_W-1:0]                 send_prios;
        logic [MAX_PRIO-1:0][VALUE_W-1:0]  send_time;
        logic [PRIO_W-1:0]                 paused;
        logic [CNT_W-1:0]                  counter;
    } pfc_result_t;

    logic                              aclk = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              s_valid = 1'b0;
    wire                               s_ready;
    cmd_t                              s_command = CMD_RX;
    logic [PRIO_W-1:0]                 s_frame_priorities = '0;
    logic [VALUE_W-1:0]                s_quanta = '0;
    logic [MAX_PRIO-1:0][VALUE_W-1:0]  s_value = '0;
    wire                               m_valid;
    logic                              m_ready = 1'b0;
    wire                               m_send_valid;
    wire  [PRIO_W-1:0]                 m_send_priorities;
    wire  [MAX_PRIO-1:0][VALUE_W-1:0]  m_send_time;
    wire  [PRIO_W-1:0]                 m_paused_mask;
    wire  [CNT_W-1:0]                  m_counter_value;
    logic                              cfg_valid = 1'b0;
    wire                               cfg_ready;
    cfg_idx_t                          cfg_index = REG_PFC_ENABLE;
    logic [CFG_DATA_W-1:0]             cfg_data = '0;

    // predictor configuration and state
    logic                              pfc_on = 1'b0;
    logic [MAX_PRIO-1:0]               prio_on = '0;
    logic [MAX_PRIO-1:0][VALUE_W-1:0]  thr_lane = '0;
    logic [MAX_PRIO-1:0][VALUE_W-1:0]  ptime_lane = '0;
    logic [VALUE_W-1:0]                pause_left [MAX_PRIO];
    logic                              pause_sent [MAX_PRIO];
    logic [CNT_W-1:0]                  paused_quanta [MAX_PRIO];
    logic [CNT_W-1:0]                  rx_frame_cnt = '0;
    logic [CNT_W-1:0]                  tx_frame_cnt = '0;

    pfc_item_t                         cmd_q [$];
    pfc_result_t                       result_q [$];
    logic                              s_taken = 1'b0;
    logic                              idle_on = 1'b1;
    int unsigned                       hold_asked = 0;
    int unsigned                       mismatches = 0;

    priority_flow_control_manager i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_command          (s_command),
        .s_frame_priorities (s_frame_priorities),
        .s_quanta           (s_quanta),
        .s_value_0          (s_value[0]),
        .s_value_1          (s_value[1]),
        .s_value_2          (s_value[2]),
        .s_value_3          (s_value[3]),
        .s_value_4          (s_value[4]),
        .s_value_5          (s_value[5]),
        .s_value_6          (s_value[6]),
        .s_value_7          (s_value[7]),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_send_valid       (m_send_valid),
        .m_send_priorities  (m_send_priorities),
        .m_send_time_0      (m_send_time[0]),
        .m_send_time_1      (m_send_time[1]),
        .m_send_time_2      (m_send_time[2]),
        .m_send_time_3      (m_send_time[3]),
        .m_send_time_4      (m_send_time[4]),
        .m_send_time_5      (m_send_time[5]),
        .m_send_time_6      (m_send_time[6]),
        .m_send_time_7      (m_send_time[7]),
        .m_paused_mask      (m_paused_mask),
        .m_counter_value    (m_counter_value),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    always #2 aclk = ~aclk;

    initial begin
        for (int p = 0; p < MAX_PRIO; p++) begin
            pause_left[p] = '0;
            pause_sent[p] = 1'b0;
            paused_quanta[p] = '0;
        end
    end

    function automatic pfc_result_t pfc_step(input pfc_item_t it);
        pfc_result_t         r;
        logic [VALUE_W-1:0]  th;
        logic [VALUE_W-1:0]  idx;
        r = '0;
        case (it.cmd)
            CMD_RX: begin
                if (pfc_on) begin
                    rx_frame_cnt += 1;
                    for (int p = 0; p < MAX_PRIO; p++)
                        if (prio_on[p] && it.prios[p])
                            pause_left[p] = it.value[p];
                end
            end
            CMD_TICK: begin
                for (int p = 0; p < MAX_PRIO; p++) begin
                    if (pause_left[p] != 0) begin
                        if (it.quanta >= pause_left[p]) begin
                            paused_quanta[p] += pause_left[p];
                            pause_left[p] = '0;
                        end else begin
                            pause_left[p] -= it.quanta;
                            paused_quanta[p] += it.quanta;
                        end
                    end
                end
            end
            CMD_GEN: begin
                if (pfc_on) begin
                    for (int p = 0; p < MAX_PRIO; p++) begin
                        th = thr_lane[p];
                        if (prio_on[p]) begin
                            if (it.value[p] >= th && !pause_sent[p]) begin
                                r.send_prios[p] = 1'b1;
                                r.send_time[p] = ptime_lane[p];
                                pause_sent[p] = 1'b1;
                                r.send = 1'b1;
                            end else if (it.value[p] < (th >> 1) && pause_sent[p]) begin
                                r.send_prios[p] = 1'b1;
                                pause_sent[p] = 1'b0;
                                r.send = 1'b1;
                            end
                        end
                    end
                    if (r.send)
                        tx_frame_cnt += 1;
                end
            end
            default: begin
                idx = it.value[0];
                if (idx == CNT_IDX_RX)
                    r.counter = rx_frame_cnt;
                else if (idx == CNT_IDX_TX)
                    r.counter = tx_frame_cnt;
                else if (idx >= CNT_IDX_PAUSE_BASE && idx < CNT_IDX_PAUSE_BASE + MAX_PRIO)
                    r.counter = paused_quanta[idx - CNT_IDX_PAUSE_BASE];
            end
        endcase
        for (int p = 0; p < MAX_PRIO; p++)
            r.paused[p] = prio_on[p] && (pause_left[p] != 0);
        return r;
    endfunction

    function automatic void check_field(input string what, input logic [CNT_W-1:0] want,
                                        input logic [CNT_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // accept side predicts, result side checks against the oldest prediction
    always @(posedge aclk) begin : scoreboard
        pfc_item_t    it;
        pfc_result_t  got;
        pfc_result_t  want;
        if (aresetn && s_valid && s_ready) begin
            it.cmd = s_command;
            it.prios = s_frame_priorities;
            it.quanta = s_quanta;
            it.value = s_value;
            result_q.push_back(pfc_step(it));
        end
        s_taken <= aresetn && s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            got.send = m_send_valid;
            got.send_prios = m_send_priorities;
            got.send_time = m_send_time;
            got.paused = m_paused_mask;
            got.counter = m_counter_value;
            if (result_q.size() == 0) begin
                $display("%0t: unexpected result transaction, nothing pending", $time);
                mismatches++;
            end else begin
                want = result_q.pop_front();
                check_field("send_valid", want.send, got.send);
                check_field("send_priorities", want.send_prios, got.send_prios);
                for (int p = 0; p < MAX_PRIO; p++)
                    check_field($sformatf("send_time_%0d", p), want.send_time[p],
                                got.send_time[p]);
                check_field("paused_mask", want.paused, got.paused);
                check_field("counter_value", want.counter, got.counter);
            end
        end
    end

    always @(negedge aclk) begin : cmd_driver
        pfc_item_t it;
        if (aresetn && (!s_valid || s_taken)) begin
            if (cmd_q.size() != 0 && !(idle_on && $urandom_range(0, 99) < 8)) begin
                it = cmd_q.pop_front();
                s_command <= it.cmd;
                s_frame_priorities <= it.prios;
                s_quanta <= it.quanta;
                s_value <= it.value;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin : result_sink
        int unsigned hold_left;
        int unsigned hold_done;
        if (!aresetn) begin
            hold_left = 0;
            hold_done = 0;
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_done != hold_asked) begin
            hold_done++;
            hold_left = 150;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !(idle_on && $urandom_range(0, 99) < 8);
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (idx)
            REG_PFC_ENABLE:      pfc_on = data[0];
            REG_PRIO_MASK:       prio_on = data[PRIO_W-1:0];
            REG_THRESHOLD_LOW:   thr_lane[3:0] = data;
            REG_THRESHOLD_HIGH:  thr_lane[7:4] = data;
            REG_PAUSE_TIME_LOW:  ptime_lane[3:0] = data;
            REG_PAUSE_TIME_HIGH: ptime_lane[7:4] = data;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic en, input logic [PRIO_W-1:0] mask,
                             input logic [CFG_DATA_W-1:0] thr_lo, thr_hi, pt_lo, pt_hi);
        write_reg(REG_PFC_ENABLE, {63'(0), en});
        write_reg(REG_PRIO_MASK, {56'(0), mask});
        write_reg(REG_THRESHOLD_LOW, thr_lo);
        write_reg(REG_THRESHOLD_HIGH, thr_hi);
        write_reg(REG_PAUSE_TIME_LOW, pt_lo);
        write_reg(REG_PAUSE_TIME_HIGH, pt_hi);
    endtask

    task automatic wait_drained();
        while (cmd_q.size() != 0 || s_valid || result_q.size() != 0)
            @(posedge aclk);
    endtask

    function automatic pfc_item_t mk(input cmd_t cmd, input logic [PRIO_W-1:0] prios,
                                     input logic [VALUE_W-1:0] quanta,
                                     input logic [MAX_PRIO-1:0][VALUE_W-1:0] value);
        pfc_item_t it;
        it.cmd = cmd;
        it.prios = prios;
        it.quanta = quanta;
        it.value = value;
        return it;
    endfunction

    function automatic pfc_item_t mk_read(input logic [VALUE_W-1:0] idx);
        return mk(CMD_READ, 8'h00, 16'h0000, {112'(0), idx});
    endfunction

    // queue depth aimed at the pause / resume boundaries of a threshold
    function automatic logic [VALUE_W-1:0] pick_depth(input logic [VALUE_W-1:0] th);
        int t;
        int d;
        t = th;
        case ($urandom_range(0, 5))
            0: d = t + $urandom_range(0, 20);
            1: d = t;
            2: d = (t / 2 > 0) ? t / 2 - 1 : 0;
            3: d = (t / 2 > 0) ? $urandom_range(0, t / 2 - 1) : 0;
            4: d = $urandom_range(t / 2, (t > 0) ? t - 1 : 0);
            default: d = $urandom_range(0, 65535);
        endcase
        if (d > 65535)
            d = 65535;
        return VALUE_W'(d);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_lanes();
        logic [3:0][VALUE_W-1:0] w;
        for (int i = 0; i < 4; i++)
            w[i] = ($urandom_range(0, 7) == 0) ? VALUE_W'($urandom_range(0, 65535))
                                               : VALUE_W'($urandom_range(0, 300));
        return w;
    endfunction

    function automatic pfc_item_t rand_item();
        pfc_item_t    it;
        int unsigned  r;
        r = $urandom_range(0, 99);
        it.cmd = (r < 30) ? CMD_RX : (r < 55) ? CMD_TICK : (r < 85) ? CMD_GEN : CMD_READ;
        it.prios = PRIO_W'($urandom_range(0, 255));
        it.quanta = ($urandom_range(0, 7) == 0) ? VALUE_W'($urandom_range(0, 65535))
                                                : VALUE_W'($urandom_range(0, 120));
        for (int p = 0; p < MAX_PRIO; p++)
            it.value[p] = VALUE_W'($urandom_range(0, 65535));
        case (it.cmd)
            CMD_RX: begin
                for (int p = 0; p < MAX_PRIO; p++)
                    if ($urandom_range(0, 7) != 0)
                        it.value[p] = VALUE_W'($urandom_range(0, 400));
            end
            CMD_GEN: begin
                for (int p = 0; p < MAX_PRIO; p++)
                    it.value[p] = pick_depth(thr_lane[p]);
            end
            CMD_READ: begin
                if ($urandom_range(0, 9) != 0)
                    it.value[0] = VALUE_W'($urandom_range(0, 11));
            end
            default: ;
        endcase
        return it;
    endfunction

    initial begin : stimulus
        logic [PRIO_W-1:0] mask;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // reset configuration: PFC disabled
        cmd_q.push_back(mk(CMD_RX, 8'hFF, 16'h0000, {8{16'hFFFF}}));
        cmd_q.push_back(mk(CMD_GEN, 8'h00, 16'h0000, {8{16'hFFFF}}));
        cmd_q.push_back(mk(CMD_TICK, 8'h00, 16'd5, {8{16'h0000}}));
        cmd_q.push_back(mk_read(CNT_IDX_RX));
        wait_drained();

        configure(1'b1, 8'hFF,
                  {16'd300, 16'd200, 16'd100, 16'd0},
                  {16'hFFFF, 16'd1, 16'd2, 16'd600},
                  {16'd7, 16'd0, 16'hFFFF, 16'h1234},
                  {16'hFFFF, 16'h0001, 16'h8000, 16'h00FF});
        write_reg(cfg_idx_t'(REG_PAUSE_TIME_HIGH + 1), '1);
        write_reg('1, '1);
        cmd_q.push_back(mk(CMD_RX, 8'hFF, 16'h0000,
                           {16'd50, 16'hFFFF, 16'd0, 16'd300, 16'd100, 16'd2, 16'd1, 16'hFFFF}));
        cmd_q.push_back(mk(CMD_TICK, 8'h00, 16'd0, {8{16'h0000}}));
        cmd_q.push_back(mk(CMD_TICK, 8'h00, 16'd1, {8{16'h0000}}));
        cmd_q.push_back(mk(CMD_RX, 8'h0F, 16'h0000, {8{16'd500}}));
        cmd_q.push_back(mk(CMD_TICK, 8'h00, 16'hFFFF, {8{16'h0000}}));
        cmd_q.push_back(mk(CMD_GEN, 8'h00, 16'h0000, {8{16'hFFFF}}));
        cmd_q.push_back(mk(CMD_GEN, 8'h00, 16'h0000, {8{16'hFFFF}}));
        cmd_q.push_back(mk(CMD_GEN, 8'h00, 16'h0000, {8{16'h0000}}));
        cmd_q.push_back(mk(CMD_GEN, 8'h00, 16'h0000,
                           {16'hFFFE, 16'd1, 16'd2, 16'd300, 16'd150, 16'd100, 16'd50, 16'd0}));
        for (int i = 0; i < 10; i++)
            cmd_q.push_back(mk_read(VALUE_W'(i)));
        cmd_q.push_back(mk_read(16'hFFFF));
        wait_drained();

        write_reg(REG_PRIO_MASK, 64'h5A);
        cmd_q.push_back(mk(CMD_RX, 8'hFF, 16'h0000, {8{16'd9}}));
        wait_drained();
        write_reg(REG_PRIO_MASK, 64'h0);
        cmd_q.push_back(mk(CMD_RX, 8'hFF, 16'h0000, {8{16'd9}}));
        cmd_q.push_back(mk(CMD_TICK, 8'h00, 16'd4, {8{16'h0000}}));
        wait_drained();

        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0: configure(1'b1, 8'hFF, '1, '1, '1, '1);
                1: configure(1'b1, 8'hFF, '0, '0, '0, '0);
                2: configure(1'b0, 8'hFF, rand_lanes(), rand_lanes(),
                             {$urandom, $urandom}, {$urandom, $urandom});
                default: begin
                    mask = ($urandom_range(0, 3) == 0) ? 8'hFF : PRIO_W'($urandom_range(0, 255));
                    configure($urandom_range(0, 7) != 0, mask, rand_lanes(), rand_lanes(),
                              {$urandom, $urandom}, {$urandom, $urandom});
                end
            endcase
            idle_on = (ph != 5);
            if (ph == 7)
                hold_asked++;
            repeat (110)
                cmd_q.push_back(rand_item());
            wait_drained();
        end

        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("PASS priority_flow_control_manager");
        else
            $display("FAIL priority_flow_control_manager");
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("FAIL priority_flow_control_manager");
        $finish;
    end

endmodule
